FILE: hw/rtl/halfwave_peak_scaling_mixer_macros.svh
// Assertion macros for the half-wave peak scaling mixer.
`ifndef HALFWAVE_PEAK_SCALING_MIXER_MACROS_SVH
`define HALFWAVE_PEAK_SCALING_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define HPSM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define HPSM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define HPSM_ASSERT_IMPL(label, clk, rst_n, prop)
`define HPSM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/hpsm_pkg.sv
package hpsm_pkg;
    localparam int SOURCES_DEF = 8;
    localparam int SEGMENT_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int VAL_W = 35;
    localparam int CFG_W = 32;
    localparam logic CFG_MIN_LEVEL = 1'b0;
    localparam logic CFG_MAX_LEVEL = 1'b1;
    localparam logic KIND_MIX = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  source_count;
        logic [31:0] sample_7;
        logic [31:0] sample_6;
        logic [31:0] sample_5;
        logic [31:0] sample_4;
        logic [31:0] sample_3;
        logic [31:0] sample_2;
        logic [31:0] sample_1;
        logic [31:0] sample_0;
    } t_in;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [66:0] dividend;
        logic [34:0] divisor;
    } t_div_req;
endpackage

FILE: hw/rtl/hpsm_divider.sv
module hpsm_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpsm_pkg::t_div_req i_req,
    output logic              o_busy,
    output logic [66:0]       o_quot
);
    import hpsm_pkg::*;

    // Restoring division, one quotient bit per cycle.
    logic [66:0] r_q, n_q;
    logic [35:0] r_rem, n_rem;
    logic [34:0] r_d;
    logic [6:0]  r_cnt, n_cnt;
    logic [35:0] w_sh;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        w_sh  = {r_rem[34:0], r_q[66]};
        if (i_req.start) begin
            n_q   = i_req.dividend;
            n_rem = '0;
            n_cnt = 7'd67;
        end else if (r_cnt != 7'd0) begin
            n_q = {r_q[65:0], 1'b0};
            if (w_sh >= {1'b0, r_d}) begin
                n_rem  = w_sh - {1'b0, r_d};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_d <= i_req.divisor;
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quot = r_q;
endmodule

FILE: hw/rtl/halfwave_peak_scaling_mixer.sv
// Half-wave peak scaling mixer.
// Input channel: i_in_valid / o_in_stall carry one t_in item per transfer.
// A mix item adds source_count samples (taken as SAMPLE_BITS-bit values) one
// per cycle and appends the sum to the open segment. A sum of the opposite
// sign, a full store or a flush item emits the stored segment first.
// Output channel: o_out_valid / i_out_stall carry one t_out result per
// transfer; last_of_run marks the final result caused by one input item.
// A mix item that emits nothing passes through the sum and append states.
// Each emitted value takes a store read state and a multiply state before
// the output state. When the segment's peak is out of range, a divider
// start state and a wait in the serial divider come between the multiply
// and output states.
// One item is worked on at a time; o_in_stall is high until its results
// have all been handed to the output register.
// A stalled receiver holds the current result in the output register and
// the sequencer waits on it.
// Reset clears the segment count, the phase and the output valid, and
// reloads the peaks from the reset register values. The segment store needs
// no clearing since the count guards every read.
// Configuration writes through i_cfg_we take effect at once for limits and
// at the next segment for the peak start values.
module halfwave_peak_scaling_mixer #(
    parameter int SOURCES       = hpsm_pkg::SOURCES_DEF,
    parameter int SEGMENT_DEPTH = hpsm_pkg::SEGMENT_DEPTH_DEF,
    parameter int SAMPLE_BITS   = hpsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  hpsm_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output hpsm_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [hpsm_pkg::CFG_W-1:0] i_cfg_data
);
    import hpsm_pkg::*;
`include "halfwave_peak_scaling_mixer_macros.svh"

    localparam int AW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
    localparam int CW = $clog2(SEGMENT_DEPTH + 1);
    localparam int SW = $clog2(SOURCES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_APP  = 3'd6;
    localparam logic [2:0] S_DST  = 3'd7;

    logic [2:0] r_state, n_state;
    logic signed [31:0] r_min;
    logic [30:0] r_max;
    logic signed [VAL_W-1:0] r_mem [SEGMENT_DEPTH];
    logic [CW-1:0] r_cnt;
    logic r_neg;
    logic signed [VAL_W-1:0] r_lo, r_hi;
    logic r_kind;
    logic [SW-1:0] r_nsrc, r_j;
    logic [SAMPLE_BITS-1:0] r_smp [SOURCES];
    logic signed [VAL_W-1:0] r_sum;
    logic [CW-1:0] r_idx, r_n;
    logic r_app, r_scaled, r_negres;
    logic signed [VAL_W-1:0] r_rd;
    logic [31:0] r_lim_mag;
    logic [34:0] r_pk_mag;
    logic [66:0] r_prod;
    logic [31:0] r_val;
    logic [31:0] r_res;
    logic r_last;
    logic r_ovalid;
    t_div_req w_req;
    logic w_busy;
    logic [66:0] w_quot;
    logic [31:0] w_raw [8];

    assign w_raw = '{i_in.sample_0, i_in.sample_1, i_in.sample_2, i_in.sample_3,
                     i_in.sample_4, i_in.sample_5, i_in.sample_6, i_in.sample_7};

    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out.sample_out = r_res;
    assign o_out.last_of_run = r_last;

    // Scaling choice for the open segment.
    logic signed [VAL_W-1:0] w_minx, w_maxx, w_lim, w_pk;
    logic w_sc;
    always_comb begin
        w_minx = VAL_W'(r_min);
        w_maxx = VAL_W'($signed({1'b0, r_max}));
        w_lim = '0;
        w_pk  = '0;
        w_sc  = 1'b0;
        if (r_lo < w_minx) begin
            w_lim = w_minx; w_pk = r_lo; w_sc = 1'b1;
        end else if (r_hi > w_maxx) begin
            w_lim = w_maxx; w_pk = r_hi; w_sc = 1'b1;
        end
        if (w_pk == '0) w_sc = 1'b0;
    end

    logic signed [VAL_W-1:0] w_add;
    assign w_add = $signed(r_smp[r_j[$clog2(SOURCES)>0?$clog2(SOURCES)-1:0:0]]);

    logic w_opp, w_full;
    assign w_opp  = r_neg ? (r_sum > 0) : (r_sum < 0);
    assign w_full = (r_cnt >= CW'(SEGMENT_DEPTH));

    logic [34:0] w_vmag;
    assign w_vmag = r_rd[VAL_W-1] ? 35'(-r_rd) : 35'(r_rd);

    // The product is registered in the multiply cycle and handed to the
    // divider in the next cycle, the divider start state.
    always_comb begin
        w_req.start    = (r_state == S_DST);
        w_req.dividend = r_prod;
        w_req.divisor  = r_pk_mag;
    end

    hpsm_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_busy (w_busy),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= -32'sd32768;
            r_max    <= 31'd32767;
            r_cnt    <= '0;
            r_neg    <= 1'b0;
            r_lo     <= VAL_W'(32767);
            r_hi     <= -VAL_W'(32768);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MIN_LEVEL) r_min <= $signed(i_cfg_data);
                else r_max <= i_cfg_data[30:0];
            end
            if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_kind <= i_in.kind;
                        r_nsrc <= (i_in.source_count > 4'(SOURCES)) ? SW'(SOURCES)
                                                                    : SW'(i_in.source_count);
                        for (int k = 0; k < SOURCES; k++) r_smp[k] <= w_raw[k][SAMPLE_BITS-1:0];
                        r_sum <= '0;
                        r_j   <= '0;
                        if (i_in.kind == KIND_FLUSH) begin
                            r_app <= 1'b0;
                            r_idx <= '0; r_n <= r_cnt;
                            r_scaled <= w_sc;
                            r_lim_mag <= w_lim[VAL_W-1] ? 32'(-w_lim) : 32'(w_lim);
                            r_pk_mag  <= w_pk[VAL_W-1] ? 35'(-w_pk) : 35'(w_pk);
                            r_negres  <= w_lim[VAL_W-1] ^ w_pk[VAL_W-1];
                            r_state <= (r_cnt != '0) ? S_RD : S_APP;
                        end else if (i_in.source_count != 4'd0) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (r_j == r_nsrc) begin
                        r_app <= 1'b1;
                        r_idx <= '0; r_n <= r_cnt;
                        r_scaled <= w_sc;
                        r_lim_mag <= w_lim[VAL_W-1] ? 32'(-w_lim) : 32'(w_lim);
                        r_pk_mag  <= w_pk[VAL_W-1] ? 35'(-w_pk) : 35'(w_pk);
                        r_negres  <= w_lim[VAL_W-1] ^ w_pk[VAL_W-1];
                        if (w_opp) r_neg <= !r_neg;
                        if ((w_opp || w_full) && r_cnt != '0) r_state <= S_RD;
                        else r_state <= S_APP;
                        // A sign change on an empty segment still restarts the
                        // peaks from the current register values.
                        if (w_opp && r_cnt == '0) begin
                            r_lo <= VAL_W'($signed({1'b0, r_max}));
                            r_hi <= VAL_W'(r_min);
                        end
                    end else begin
                        r_sum <= r_sum + w_add;
                        r_j   <= r_j + SW'(1);
                    end
                end
                S_RD: begin
                    r_rd <= r_mem[r_idx[AW-1:0]];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= 67'(w_vmag) * 67'(r_lim_mag);
                    r_negres <= r_negres;
                    if (r_scaled) r_state <= S_DST;
                    else begin
                        r_val <= r_rd[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_DST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_busy) begin
                        r_val <= ((r_rd[VAL_W-1] ^ r_negres) ? -w_quot[31:0] : w_quot[31:0]);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_res <= r_val;
                        r_last <= (r_idx + CW'(1) == r_n);
                        if (r_idx + CW'(1) == r_n) begin
                            r_cnt <= '0;
                            r_lo <= VAL_W'($signed({1'b0, r_max}));
                            r_hi <= VAL_W'(r_min);
                            r_state <= S_APP;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_APP: begin
                    if (!r_app) begin
                        if (r_kind == KIND_FLUSH) begin
                            r_cnt <= '0;
                            r_lo <= VAL_W'($signed({1'b0, r_max}));
                            r_hi <= VAL_W'(r_min);
                        end
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || !i_out_stall) begin
                        r_mem[r_cnt[AW-1:0]] <= r_sum;
                        r_cnt <= r_cnt + CW'(1);
                        if (r_sum < r_lo) r_lo <= r_sum;
                        if (r_sum > r_hi) r_hi <= r_sum;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HPSM_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_cnt <= CW'(SEGMENT_DEPTH))
    `HPSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    `HPSM_ASSERT_IMPL(a_idle_ready, i_clk, i_rst_n, (r_state == S_IDLE) == !o_in_stall)
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hpsm_pkg::*;

    // Clock and reset.
    logic i_clk;
    logic i_rst_n;

    // Input channel.
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;

    // Output channel.
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    // Register write port.
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    halfwave_peak_scaling_mixer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the mixer's state. Values are kept as 64-bit signed
    // integers, which is ample for the 35-bit sums the block stores.
    longint lvl_min;
    longint lvl_max;
    longint seg_vals[64];
    int     seg_len;
    bit     in_negative;
    longint peak_lo;
    longint peak_hi;

    // Results that the mixer still owes, oldest first.
    t_out   owed_samples[$];

    int     fail_count;
    int     idle_cycles;
    int     results_seen;
    int     scaled_segments;
    int     forced_segments;
    bit     stim_done;

    localparam int WATCHDOG_LIMIT = 200000;

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Exact trunc(v * lim / pk). The product of a 35-bit value and a 32-bit
    // limit needs 67 bits, so the division is done on 128-bit magnitudes.
    function automatic logic [31:0] rescale(longint v, longint lim, longint pk);
        logic [127:0] prod;
        logic [127:0] quot;
        bit           neg;
        prod = 128'(mag(v)) * 128'(mag(lim));
        quot = prod / 128'(mag(pk));
        neg  = ((v < 0) != (lim < 0)) != (pk < 0);
        if (neg) begin
            quot = -quot;
        end
        return quot[31:0];
    endfunction

    function automatic void reopen_segment();
        seg_len = 0;
        peak_lo = lvl_max;
        peak_hi = lvl_min;
    endfunction

    // Queue every stored value of the open segment, scaled when its peak
    // leaves the configured range, then start an empty segment.
    function automatic void release_segment();
        longint lim;
        longint pk;
        bit     scale_on;
        t_out   r;
        lim = 0;
        pk = 0;
        scale_on = 1'b0;
        if (peak_lo < lvl_min) begin
            lim = lvl_min;
            pk = peak_lo;
            scale_on = 1'b1;
        end else if (peak_hi > lvl_max) begin
            lim = lvl_max;
            pk = peak_hi;
            scale_on = 1'b1;
        end
        if (pk == 0) begin
            scale_on = 1'b0;
        end
        if (scale_on && seg_len > 0) begin
            scaled_segments++;
        end
        for (int k = 0; k < seg_len; k++) begin
            r.sample_out  = scale_on ? rescale(seg_vals[k], lim, pk) : seg_vals[k][31:0];
            r.last_of_run = (k + 1 == seg_len);
            owed_samples.push_back(r);
        end
        reopen_segment();
    endfunction

    // Work out what one accepted transfer causes.
    function automatic void predict_mix(t_in it);
        int     cnt;
        longint total;
        logic [31:0] s [8];
        bit     flips;
        if (it.kind == KIND_FLUSH) begin
            release_segment();
            return;
        end
        cnt = int'(it.source_count);
        if (cnt == 0) begin
            return;
        end
        if (cnt > 8) begin
            cnt = 8;
        end
        s = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
              it.sample_4, it.sample_5, it.sample_6, it.sample_7};
        total = 0;
        for (int k = 0; k < cnt; k++) begin
            total += longint'(signed'(s[k]));
        end
        flips = in_negative ? (total > 0) : (total < 0);
        if (flips) begin
            release_segment();
            in_negative = !in_negative;
        end else if (seg_len >= 64) begin
            forced_segments++;
            release_segment();
        end
        if (seg_len < 64) begin
            seg_vals[seg_len] = total;
            seg_len++;
        end
        if (total < peak_lo) begin
            peak_lo = total;
        end
        if (total > peak_hi) begin
            peak_hi = total;
        end
    endfunction

    // Output side: compare each transfer with the oldest
    // owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (owed_samples.size() == 0) begin
                $error("unexpected result sample_out=%0d last_of_run=%0b",
                       $signed(o_out.sample_out), o_out.last_of_run);
                fail_count++;
            end else begin
                t_out want;
                want = owed_samples.pop_front();
                if (o_out.sample_out !== want.sample_out) begin
                    $error("sample_out expected %0d actual %0d",
                           $signed(want.sample_out), $signed(o_out.sample_out));
                    fail_count++;
                end
                if (o_out.last_of_run !== want.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b",
                           want.last_of_run, o_out.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall: long quiet stretches, mostly short stalls, a few long.
    initial begin
        int r;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 40)) @(posedge i_clk);
            end else if (r < 30) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one transfer and hold it until the mixer takes it.
    task automatic send_item(t_in it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_mix(it);
        if ($urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_samples.size() != 0) @(posedge i_clk);
        // An item that emits nothing may still be summing its sources.
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_level(logic idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_MIN_LEVEL) begin
            lvl_min = longint'(signed'(val));
        end else begin
            lvl_max = longint'(val[30:0]);
        end
    endtask

    function automatic t_in mix_item(int cnt, longint a, longint b);
        t_in it;
        it = '0;
        it.kind         = KIND_MIX;
        it.source_count = 4'(cnt);
        it.sample_0     = a[31:0];
        it.sample_1     = b[31:0];
        return it;
    endfunction

    function automatic logic [31:0] rand_sample(int scale_sel);
        case (scale_sel)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 60000)) - 30000);
            default: return 32'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    // A random item. Most items continue or flip a half wave with samples
    // of moderate size; the rest are full-range noise, flushes and zero
    // source counts.
    function automatic t_in rand_item();
        t_in it;
        int  r;
        int  sel;
        r = $urandom_range(0, 99);
        it = '0;
        it.sample_0 = $urandom();
        it.sample_1 = $urandom();
        it.sample_2 = $urandom();
        it.sample_3 = $urandom();
        it.sample_4 = $urandom();
        it.sample_5 = $urandom();
        it.sample_6 = $urandom();
        it.sample_7 = $urandom();
        it.kind = KIND_MIX;
        it.source_count = 4'($urandom_range(1, 8));
        if (r < 6) begin
            it.kind = KIND_FLUSH;
            it.source_count = 4'($urandom());
        end else if (r < 10) begin
            it.source_count = 4'($urandom_range(0, 15));
        end else if (r < 80) begin
            sel = ($urandom_range(0, 3) == 0) ? 1 : 2;
            it.sample_0 = rand_sample(sel);
            it.sample_1 = rand_sample(sel);
            it.sample_2 = rand_sample(sel);
            it.sample_3 = rand_sample(sel);
            it.sample_4 = rand_sample(sel);
            it.sample_5 = rand_sample(sel);
            it.sample_6 = rand_sample(sel);
            it.sample_7 = rand_sample(sel);
        end
        return it;
    endfunction

    // Directed rows. Expected results are typed in only where obvious:
    // a lone value that stays in range comes back unchanged on flush.
    typedef struct {
        t_in  item;
        bit   has_known;
        t_out known;
    } t_row;

    t_row rows[$];

    task automatic add_row(t_in it, bit known_ok = 1'b0, longint val = 0);
        t_row r;
        r.item                  = it;
        r.has_known             = known_ok;
        r.known.sample_out      = val[31:0];
        r.known.last_of_run     = 1'b1;
        rows.push_back(r);
    endtask

    initial begin
        t_in flush_it;
        t_in it;
        int  items_sent;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MIN_LEVEL;
        i_cfg_data  = '0;
        fail_count  = 0;
        idle_cycles = 0;
        results_seen = 0;
        scaled_segments = 0;
        forced_segments = 0;
        stim_done   = 1'b0;
        lvl_min     = -32768;
        lvl_max     = 32767;
        in_negative = 1'b0;
        reopen_segment();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        flush_it = '0;
        flush_it.kind = KIND_FLUSH;

        // Flush of an empty segment after reset, and a mix with no sources.
        add_row(flush_it);
        add_row(mix_item(0, 5, 5));
        // A single value in range, flushed unchanged.
        add_row(mix_item(1, 1234, 0));
        add_row(flush_it, 1'b1, 1234);
        // A negative value opens the negative phase and is flushed unchanged.
        add_row(mix_item(1, -1, 0));
        add_row(flush_it, 1'b1, -1);
        // Positive peak above max_level is scaled down to max_level.
        add_row(mix_item(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_row(mix_item(1, 100, 0));
        add_row(flush_it);
        // Negative extreme, scaled to min_level.
        add_row(mix_item(8, -2147483648, -2147483648));
        add_row(mix_item(1, -7, 0));
        // Sign change closes the negative segment.
        add_row(mix_item(1, 40000, 0));
        add_row(mix_item(1, 0, 0));
        // Count above eight is taken as eight.
        it = mix_item(15, 1, 1);
        it.sample_2 = 1; it.sample_3 = 1; it.sample_4 = 1;
        it.sample_5 = 1; it.sample_6 = 1; it.sample_7 = 1;
        add_row(it);
        add_row(mix_item(1, -3, 0));
        add_row(flush_it);

        foreach (rows[k]) begin
            send_item(rows[k].item);
            if (rows[k].has_known && owed_samples.size() > 0 &&
                    owed_samples[$] !== rows[k].known) begin
                $error("sample_out expected %0d actual %0d",
                       $signed(rows[k].known.sample_out),
                       $signed(owed_samples[$].sample_out));
                fail_count++;
            end
        end
        send_item(flush_it);
        wait_drained();

        // Full store: 70 same-sign values force an emission at 64.
        for (int k = 0; k < 70; k++) begin
            send_item(mix_item(1, $urandom_range(1, 30000), 0));
        end
        send_item(flush_it);
        wait_drained();

        // Random phases at several register settings, extremes included.
        // The peaks of the next segment still start from the values that
        // were set when the last segment was emitted.
        items_sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_level(CFG_MIN_LEVEL, -100); write_level(CFG_MAX_LEVEL, 100); end
                1: begin write_level(CFG_MIN_LEVEL, 32'h8000_0000);
                         write_level(CFG_MAX_LEVEL, 32'h7FFF_FFFF); end
                2: begin write_level(CFG_MIN_LEVEL, -1); write_level(CFG_MAX_LEVEL, 1); end
                3: begin write_level(CFG_MIN_LEVEL, $urandom() | 32'h8000_0000);
                         write_level(CFG_MAX_LEVEL, $urandom_range(1, 32'h7FFF_FFFF)); end
                default: begin write_level(CFG_MIN_LEVEL, -32768);
                               write_level(CFG_MAX_LEVEL, 32767); end
            endcase
            for (int k = 0; k < 44; k++) begin
                it = rand_item();
                send_item(it);
                if (!(it.kind == KIND_MIX && it.source_count == 0)) begin
                    items_sent++;
                end
            end
            send_item(flush_it);
            wait_drained();
        end

        stim_done = 1'b1;
        repeat (200) @(posedge i_clk);
        $display("Covered %0d results over %0d random items; %0d scaled segments,",
                 results_seen, items_sent, scaled_segments);
        $display("%0d forced emissions from a full store, five register settings.",
                 forced_segments);
        if (fail_count == 0 && owed_samples.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: halfwave_peak_scaling_mixer.f
+incdir+hw/rtl
hw/rtl/hpsm_pkg.sv
hw/rtl/hpsm_divider.sv
hw/rtl/halfwave_peak_scaling_mixer.sv
bench/testbench.sv
